// ===== sv/ettd_pkg.sv =====
// Package with the command and status types shared by the totient controller and datapath.
`default_nettype none

package ettd_pkg;

   // Operand pairs that the shared divider can be started on.
   typedef enum logic [1:0] {
      DIV_REST_BY_P,
      DIV_ACC_BY_P,
      DIV_ACC_BY_REST
   } div_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        rest_take_quot;
      logic        acc_sub_quot;
      logic        next_p;
      logic        out_load;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic sq_le_rest;
      logic rest_gt_one;
      logic div_busy;
      logic div_done;
      logic rem_zero;
   } stat_type;

   localparam int FIRST_DIVISOR = 2;

endpackage

`default_nettype wire

// ===== sv/ettd_channels_if.sv =====
// Valid/ready channel interfaces for the request and response transactions.
`default_nettype none

interface ettd_req_if #(parameter int VALUE_BITS = 32);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value_in;

   modport source (output valid, output value_in, input ready);
   modport sink   (input valid, input value_in, output ready);
endinterface

interface ettd_rsp_if #(parameter int VALUE_BITS = 32);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] totient;

   modport source (output valid, output totient, input ready);
   modport sink   (input valid, input totient, output ready);
endinterface

`default_nettype wire

// ===== sv/ettd_divider.sv =====
// Restoring unsigned divider that retires one quotient bit per cycle.
`default_nettype none

module ettd_divider #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] dividend,
   input  wire logic [VALUE_BITS-1:0] divisor,
   output logic                       busy,
   output logic                       done,
   output logic [VALUE_BITS-1:0]      quot,
   output logic [VALUE_BITS-1:0]      rem
);

   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   logic                  running_ff, running_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] dsr_ff, dsr_in;

   logic [VALUE_BITS:0]   partial;
   logic [VALUE_BITS+1:0] diff;
   logic                  neg;

   always_comb begin
      partial = {rem_ff, quot_ff[VALUE_BITS-1]};
      diff    = {1'b0, partial} - {2'b00, dsr_ff};
      neg     = diff[VALUE_BITS+1];

      running_in = running_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      dsr_in     = dsr_ff;

      if (start) begin
         running_in = 1'b1;
         count_in   = CNT_W'(VALUE_BITS);
         quot_in    = dividend;
         rem_in     = '0;
         dsr_in     = divisor;
      end else if (running_ff) begin
         rem_in   = neg ? partial[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
         quot_in  = {quot_ff[VALUE_BITS-2:0], ~neg};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign busy = running_ff;
   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

// ===== sv/ettd_datapath.sv =====
// Datapath: remaining value, running result, trial divisor and its square, and the divider.
`default_nettype none

module ettd_datapath
   import ettd_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire logic [VALUE_BITS-1:0] value_in,
   output stat_type                   stat,
   output logic [VALUE_BITS-1:0]      totient
);

   localparam int SQ_W = 2 * VALUE_BITS;

   logic [VALUE_BITS-1:0] rest_ff, rest_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] p_ff, p_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [VALUE_BITS-1:0] out_ff, out_in;

   logic [VALUE_BITS-1:0] div_dividend;
   logic [VALUE_BITS-1:0] div_divisor;
   logic                  div_busy;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quot;
   logic [VALUE_BITS-1:0] div_rem;

   always_comb begin
      case (cmd.div_sel)
         DIV_REST_BY_P: begin
            div_dividend = rest_ff;
            div_divisor  = p_ff;
         end
         DIV_ACC_BY_P: begin
            div_dividend = acc_ff;
            div_divisor  = p_ff;
         end
         DIV_ACC_BY_REST: begin
            div_dividend = acc_ff;
            div_divisor  = rest_ff;
         end
         default: begin
            div_dividend = rest_ff;
            div_divisor  = p_ff;
         end
      endcase
   end

   ettd_divider #(.VALUE_BITS(VALUE_BITS)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      rest_in = rest_ff;
      acc_in  = acc_ff;
      p_in    = p_ff;
      sq_in   = sq_ff;
      out_in  = out_ff;
      if (cmd.load) begin
         rest_in = value_in;
         acc_in  = value_in;
         p_in    = VALUE_BITS'(FIRST_DIVISOR);
         sq_in   = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
      end
      if (cmd.rest_take_quot) begin
         rest_in = div_quot;
      end
      if (cmd.acc_sub_quot) begin
         acc_in = acc_ff - div_quot;
      end
      if (cmd.next_p) begin
         // (p + 1)^2 = p^2 + 2p + 1
         p_in  = p_ff + VALUE_BITS'(1);
         sq_in = sq_ff + {{(VALUE_BITS - 1){1'b0}}, p_ff, 1'b1};
      end
      if (cmd.out_load) begin
         out_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      acc_ff  <= acc_in;
      p_ff    <= p_in;
      sq_ff   <= sq_in;
      out_ff  <= out_in;
   end

   always_comb begin
      stat.sq_le_rest  = sq_ff <= {{VALUE_BITS{1'b0}}, rest_ff};
      stat.rest_gt_one = rest_ff > VALUE_BITS'(1);
      stat.div_busy    = div_busy;
      stat.div_done    = div_done;
      stat.rem_zero    = div_rem == '0;
   end

   assign totient = out_ff;

endmodule

`default_nettype wire

// ===== sv/ettd_ctrl.sv =====
// Controller state machine that sequences the trial-division loop.
`default_nettype none

module ettd_ctrl
   import ettd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIV_REST,
      ST_REDIV,
      ST_DIV_ACC,
      ST_DIV_FIN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      hit_ff, hit_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.div_sel  = DIV_REST_BY_P;
      state_in     = state_ff;
      hit_in       = hit_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               hit_in   = 1'b0;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (stat.sq_le_rest) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_REST_BY_P;
               state_in      = ST_DIV_REST;
            end else if (stat.rest_gt_one) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_ACC_BY_REST;
               state_in      = ST_DIV_FIN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV_REST: begin
            if (stat.div_done) begin
               if (stat.rem_zero) begin
                  cmd.rest_take_quot = 1'b1;
                  hit_in             = 1'b1;
                  state_in           = ST_REDIV;
               end else if (hit_ff) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_ACC_BY_P;
                  state_in      = ST_DIV_ACC;
               end else begin
                  cmd.next_p = 1'b1;
                  state_in   = ST_TEST;
               end
            end
         end
         ST_REDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_REST_BY_P;
            state_in      = ST_DIV_REST;
         end
         ST_DIV_ACC: begin
            cmd.div_sel = DIV_ACC_BY_P;
            if (stat.div_done) begin
               cmd.acc_sub_quot = 1'b1;
               cmd.next_p       = 1'b1;
               hit_in           = 1'b0;
               state_in         = ST_TEST;
            end
         end
         ST_DIV_FIN: begin
            cmd.div_sel = DIV_ACC_BY_REST;
            if (stat.div_done) begin
               cmd.acc_sub_quot = 1'b1;
               state_in         = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hit_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_ff       <= hit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

// ===== sv/euler_totient_trial_division_top.sv =====
// Top level of the Euler totient block: controller, datapath and the channel ports.
`default_nettype none

// Computes phi(n) for one unsigned VALUE_BITS-bit integer per request transaction and
// returns it in one response transaction. The block works on one value at a time:
// trial divisors p run upward from 2 while p*p does not exceed the remaining value,
// and every division goes through a single shared restoring divider. Each trial
// divisor costs one test state plus one division, a divisor that divides costs one
// more division and one restart state for each power of it plus one division for the
// result update, and a leftover prime factor costs one final division.
// The result is held in an output register, so a new request transaction is taken
// while the previous response transaction still waits on rsp_ch.ready.
// Inputs 0 and 1 give 0 and 1.
module euler_totient_trial_division_top
   import ettd_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   ettd_req_if.sink   req_ch,
   ettd_rsp_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   // The controller owns the handshakes and the loop sequencing.
   ettd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the working values, the divider and the output register.
   ettd_datapath #(.VALUE_BITS(VALUE_BITS)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .value_in (req_ch.value_in),
      .stat     (stat),
      .totient  (rsp_ch.totient)
   );

   // The divider is never restarted while it is still iterating.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !stat.div_busy)
      else $error("divider started while busy");

   // The result is only updated from a finished quotient.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.acc_sub_quot || cmd.rest_take_quot) |-> stat.div_done)
      else $error("quotient used before the divider finished");

   // Once a request transaction is taken, no other is taken in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while a value is in progress");

endmodule

`default_nettype wire

// ===== test/tb_euler_totient_trial_division_top.sv =====
// Testbench for the Euler totient block: directed and random values checked against a table or a predictor.
`timescale 1ns / 100ps

module tb_euler_totient_trial_division_top;
   import ettd_pkg::*;

   localparam int VALUE_BITS     = 32;
   localparam int DIRECTED_COUNT = 18;
   localparam int RANDOM_ITEMS   = 100;
   localparam int QUIET_ITEMS    = 15;
   localparam int HOLD_AFTER     = 25;
   localparam int HOLD_CYCLES    = 20000;
   localparam int DRAIN_CYCLES   = 200;

   // One row of the directed table. When known is set the expected totient is typed in;
   // otherwise it comes from the predictor.
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      bit                    known;
      logic [VALUE_BITS-1:0] totient;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;
   bit   quiet_tail = 1'b0;
   int   totients_seen = 0;
   int   mismatch_count = 0;

   // Totients still owed by the block, oldest first.
   logic [VALUE_BITS-1:0] pending_totients[$];

   ettd_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   ettd_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_ch ();

   euler_totient_trial_division_top #(
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The directed table covers zero, one, small primes and prime powers, a few larger
   // primes that still finish quickly, and the all-zero and all-one extremes of the field.
   // Primes whose square root is large (for example the largest 32-bit prime) are left
   // out because trial division would step through every divisor up to that root.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{32'd0,          1'b1, 32'd0},
      '{32'd1,          1'b1, 32'd1},
      '{32'd2,          1'b1, 32'd1},
      '{32'd3,          1'b1, 32'd2},
      '{32'd4,          1'b0, 32'd0},
      '{32'd6,          1'b0, 32'd0},
      '{32'd36,         1'b0, 32'd0},
      '{32'd97,         1'b1, 32'd96},
      '{32'd100,        1'b0, 32'd0},
      '{32'd720720,     1'b0, 32'd0},
      '{32'd10007,      1'b1, 32'd10006},
      '{32'd65521,      1'b1, 32'd65520},
      '{32'd65536,      1'b1, 32'd32768},
      '{32'd1000003,    1'b1, 32'd1000002},
      '{32'h8000_0000,  1'b1, 32'h4000_0000},
      '{32'hFFFF_0000,  1'b0, 32'd0},
      '{32'hFFFE_0001,  1'b0, 32'd0},
      '{32'hFFFF_FFFF,  1'b1, 32'h8000_0000}
   };

   // Predictor: phi(n) by trial division. The loop bound is tested as p <= rest / p so
   // that nothing overflows, and every prime factor is divided out completely.
   function automatic logic [VALUE_BITS-1:0] phi_of(input logic [VALUE_BITS-1:0] n);
      longint unsigned rest;
      longint unsigned acc;
      longint unsigned p;
      rest = n;
      acc  = n;
      for (p = FIRST_DIVISOR; p <= rest / p; p++) begin
         if (rest % p == 0) begin
            while (rest % p == 0) rest = rest / p;
            acc = acc - acc / p;
         end
      end
      // Whatever is left above one is a single prime factor.
      if (rest > 1) acc = acc - acc / rest;
      return acc[VALUE_BITS-1:0];
   endfunction

   // Random values built as a 12-bit seed times several factors up to 64. Such values
   // spread over all 32 bits but have no two large prime factors, so the trial division
   // never runs far past 64.
   function automatic logic [VALUE_BITS-1:0] smooth_value();
      longint unsigned v;
      longint unsigned f;
      int              steps;
      int              k;
      v     = $urandom_range(1, 4095);
      steps = $urandom_range(0, 12);
      for (k = 0; k < steps; k++) begin
         f = $urandom_range(2, 64);
         if (v * f <= 64'hFFFF_FFFF) v = v * f;
      end
      return v[VALUE_BITS-1:0];
   endfunction

   // Offers one request transaction, starting and ending at a falling edge. Outside the
   // quiet tail a random idle burst may come first. The expected totient is queued at
   // the rising edge where the transaction is accepted.
   task automatic offer(input logic [VALUE_BITS-1:0] value, input bit allow_gap,
                        input logic [VALUE_BITS-1:0] totient);
      int gap;
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_ch.valid    <= 1'b0;
         req_ch.value_in <= $urandom;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.value_in <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_totients.push_back(totient);
      @(negedge clock);
   endtask

   // Main stimulus: reset, the directed table, then the random values.
   initial begin : stimulus
      int                    i;
      logic [VALUE_BITS-1:0] v;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.value_in = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_COUNT; i++) begin
         offer(directed_rows[i].value, 1'b1,
               directed_rows[i].known ? directed_rows[i].totient
                                      : phi_of(directed_rows[i].value));
      end

      // Mostly smooth products; one in ten is a plain 16-bit value, which may be a prime
      // or have an awkward factor.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
         if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 65535);
         else v = smooth_value();
         offer(v, !quiet_tail, phi_of(v));
      end
      req_ch.valid <= 1'b0;

      // Wait for the last response transaction, then a little longer to catch any
      // response that nobody asked for.
      while (pending_totients.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Response ready. Random short stalls come and go, and once, after HOLD_AFTER
   // responses, the ready line is held low for a long stretch while the sender keeps
   // offering, so the output register and the computation both fill and the block has
   // to stall its input. In the quiet tail ready stays high.
   initial begin : rsp_ready_driver
      int idle;
      bit held;
      held         = 1'b0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && totients_seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            idle = $urandom_range(1, 6);
            rsp_ch.ready <= 1'b0;
            repeat (idle) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // Every accepted response transaction is matched against the oldest expectation.
   always @(posedge clock) begin : totient_check
      logic [VALUE_BITS-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         totients_seen <= totients_seen + 1;
         if (pending_totients.size() == 0) begin
            $display("%0t: unexpected response transaction, totient %0d", $time,
                     rsp_ch.totient);
            mismatch_count <= mismatch_count + 1;
         end else begin
            want = pending_totients.pop_front();
            if (rsp_ch.totient !== want) begin
               $display("%0t: totient mismatch: expected %0d, actual %0d", $time, want,
                        rsp_ch.totient);
               mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

   // Safety net in case the block hangs; far beyond the slowest correct run.
   initial begin : watchdog
      #200_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
